@@ design/rtbp_pkg.sv @@
// Shared types and codes for the register-table burst packer.
// Holds entry kinds, record types, controller states and the command/status
// structs that join the controller to the datapath. No dependencies.
package rtbp_pkg;

    // Default data capacity of one burst, in bytes
    localparam int DEF_MAX_BURST_BYTES = 32;

    // Entry kinds carried on the input tuser
    localparam logic [2:0] KIND_WRITE32 = 3'd0;
    localparam logic [2:0] KIND_WRITE16 = 3'd1;
    localparam logic [2:0] KIND_WRITE8  = 3'd2;
    localparam logic [2:0] KIND_POLL16  = 3'd3;
    localparam logic [2:0] KIND_WAIT    = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    // Record types carried on the output tuser
    localparam logic [2:0] REC_BYTE  = 3'd0;
    localparam logic [2:0] REC_POLL  = 3'd1;
    localparam logic [2:0] REC_WAIT  = 3'd2;
    localparam logic [2:0] REC_ERROR = 3'd3;
    localparam logic [2:0] REC_DONE  = 3'd4;

    // Width of the burst being gathered
    localparam logic [1:0] WID_NONE = 2'd0;
    localparam logic [1:0] WID_16   = 2'd1;
    localparam logic [1:0] WID_8    = 2'd2;

    // Index of the final byte of a 32-bit write message
    localparam logic [2:0] W32_LAST_BYTE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FL_HI,
        ST_FL_LO,
        ST_FL_DATA,
        ST_WR_HI,
        ST_WR_LO,
        ST_W32,
        ST_EMIT
    } state_t;

    // What the output register loads in a cycle
    typedef enum logic [2:0] {
        EM_NONE,
        EM_ADDR_HI,
        EM_ADDR_LO,
        EM_BUF,
        EM_W32,
        EM_SINGLE
    } emit_sel_t;

    typedef struct packed {
        logic      latch_entry;
        logic      decide;
        logic      wr_hi;
        logic      wr_lo;
        logic      flush_clear;
        emit_sel_t emit_sel;
        logic      run_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic halted;
        logic is_write;
        logic is_w16;
        logic is_w32;
        logic need_pre;
        logic post_flush;
        logic cnt_zero;
        logic buf_last;
        logic w32_last;
    } dp_status_t;

endpackage

@@ design/rtbp_ctrl.sv @@
// Controller state machine of the burst packer.
// Sequences flushes, buffer writes and record emission; depends on rtbp_pkg.
module rtbp_ctrl
    import rtbp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   flush_post_reg, flush_post_next;
    state_t act_state;
    state_t flush_done_state;

    // Pick the state that carries out the entry itself
    always_comb begin
        if (status.is_write) begin
            act_state = status.is_w16 ? ST_WR_HI : ST_WR_LO;
        end else begin
            act_state = status.is_w32 ? ST_W32 : ST_EMIT;
        end
        flush_done_state = flush_post_reg ? ST_IDLE : act_state;
    end

    // Next state
    always_comb begin
        state_next      = state_reg;
        flush_post_next = flush_post_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.halted) begin
                    state_next = ST_IDLE;
                end else if (status.need_pre) begin
                    state_next      = ST_FL_HI;
                    flush_post_next = 1'b0;
                end else begin
                    state_next = act_state;
                end
            end
            ST_FL_HI: begin
                if (status.out_free) begin
                    state_next = ST_FL_LO;
                end
            end
            ST_FL_LO: begin
                if (status.out_free) begin
                    state_next = status.cnt_zero ? flush_done_state : ST_FL_DATA;
                end
            end
            ST_FL_DATA: begin
                if (status.out_free && status.buf_last) begin
                    state_next = flush_done_state;
                end
            end
            ST_WR_HI: begin
                state_next = ST_WR_LO;
            end
            ST_WR_LO: begin
                if (status.post_flush) begin
                    state_next      = ST_FL_HI;
                    flush_post_next = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_W32: begin
                if (status.out_free && status.w32_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: commands to the datapath
    always_comb begin
        cmd      = '0;
        cmd.emit_sel = EM_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.latch_entry = s_tvalid;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ST_FL_HI: begin
                if (status.out_free) begin
                    cmd.emit_sel = EM_ADDR_HI;
                end
            end
            ST_FL_LO: begin
                if (status.out_free) begin
                    cmd.emit_sel = EM_ADDR_LO;
                    if (status.cnt_zero) begin
                        cmd.flush_clear = 1'b1;
                        cmd.run_last    = flush_post_reg ||
                                          (status.is_write && !status.post_flush);
                    end
                end
            end
            ST_FL_DATA: begin
                if (status.out_free) begin
                    cmd.emit_sel = EM_BUF;
                    if (status.buf_last) begin
                        cmd.flush_clear = 1'b1;
                        cmd.run_last    = flush_post_reg ||
                                          (status.is_write && !status.post_flush);
                    end
                end
            end
            ST_WR_HI: begin
                cmd.wr_hi = 1'b1;
            end
            ST_WR_LO: begin
                cmd.wr_lo = 1'b1;
            end
            ST_W32: begin
                if (status.out_free) begin
                    cmd.emit_sel = EM_W32;
                    cmd.run_last = status.w32_last;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_sel = EM_SINGLE;
                    cmd.run_last = 1'b1;
                end
            end
            default: begin
                cmd.emit_sel = EM_NONE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            flush_post_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_post_reg <= flush_post_next;
        end
    end

endmodule

@@ design/rtbp_dp.sv @@
// Datapath of the burst packer: entry latch, burst state, byte buffer and
// the output register. Driven by rtbp_ctrl; depends on rtbp_pkg.
module rtbp_dp
    import rtbp_pkg::*;
#(
    parameter int MAX_BURST_BYTES = DEF_MAX_BURST_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [2:0]  in_kind,
    input  logic [15:0] in_addr,
    input  logic [31:0] in_value,
    input  logic [15:0] in_mask,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_type,
    output logic [7:0]  out_byte,
    output logic        out_end,
    output logic [15:0] out_caddr,
    output logic [15:0] out_cval,
    output logic [15:0] out_cmask,
    output logic        out_last
);

    localparam int CNT_W = $clog2(MAX_BURST_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_BURST_BYTES);
    localparam int SUM_W = CNT_W + 2;

    // Latched entry
    logic [2:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [31:0] value_reg;
    logic [15:0] mask_reg;

    // Burst state
    logic [1:0]       pend_reg;
    logic [15:0]      start_reg;
    logic [15:0]      next_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             halted_reg;
    logic             post_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [2:0]       w32_reg;

    // Byte buffer
    logic [7:0]       buf_mem [MAX_BURST_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // Output register
    logic        valid_reg;
    logic [2:0]  type_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [15:0] caddr_reg;
    logic [15:0] cval_reg;
    logic [15:0] cmask_reg;
    logic        last_reg;

    logic             is_write, is_w16, is_bad;
    logic [1:0]       code;
    logic [SUM_W-1:0] step, base, fill, limit;
    logic             addr_top, post_comb, need_pre;
    logic [7:0]       w32_byte;

    // Classify the latched entry
    assign is_w16   = (kind_reg == KIND_WRITE16);
    assign is_write = is_w16 || (kind_reg == KIND_WRITE8);
    assign is_bad   = (kind_reg > KIND_END);
    assign code     = is_w16 ? WID_16 : WID_8;

    // Flush before the entry: anything but a contiguous write of the same width
    assign need_pre = (pend_reg != WID_NONE) &&
                      (!is_write || (pend_reg != code) || (addr_reg != next_reg));

    // Flush after the write: top of address space or no room for another value
    always_comb begin
        step      = is_w16 ? SUM_W'(2) : SUM_W'(1);
        base      = (need_pre || pend_reg == WID_NONE) ? '0 : SUM_W'(cnt_reg);
        fill      = base + step + step;
        limit     = SUM_W'(MAX_BURST_BYTES);
        addr_top  = is_w16 ? (addr_reg >= 16'hFFFE) : (addr_reg == 16'hFFFF);
        post_comb = addr_top || (fill > limit);
    end

    // Status back to the controller
    always_comb begin
        status.out_free   = !valid_reg || out_ready;
        status.halted     = halted_reg;
        status.is_write   = is_write;
        status.is_w16     = is_w16;
        status.is_w32     = (kind_reg == KIND_WRITE32);
        status.need_pre   = need_pre;
        status.post_flush = post_reg;
        status.cnt_zero   = (cnt_reg == '0);
        status.buf_last   = ((idx_reg + CNT_W'(1)) == cnt_reg);
        status.w32_last   = (w32_reg == W32_LAST_BYTE);
    end

    // Read index looks one step ahead so the registered read keeps pace
    always_comb begin
        idx_next = idx_reg;
        if (cmd.flush_clear) begin
            idx_next = '0;
        end else if (cmd.emit_sel == EM_BUF) begin
            idx_next = idx_reg + CNT_W'(1);
        end
        rd_addr = (idx_next < CNT_W'(MAX_BURST_BYTES)) ? idx_next[IDX_W-1:0] : '0;
        wr_addr = cnt_reg[IDX_W-1:0];
    end

    // Byte of a 32-bit write message
    always_comb begin
        case (w32_reg)
            3'd0:    w32_byte = addr_reg[15:8];
            3'd1:    w32_byte = addr_reg[7:0];
            3'd2:    w32_byte = value_reg[31:24];
            3'd3:    w32_byte = value_reg[23:16];
            3'd4:    w32_byte = value_reg[15:8];
            default: w32_byte = value_reg[7:0];
        endcase
    end

    // Buffer: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_hi) begin
            buf_mem[wr_addr] <= value_reg[15:8];
        end else if (cmd.wr_lo) begin
            buf_mem[wr_addr] <= value_reg[7:0];
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // Latch the entry and the post-flush decision
    always_ff @(posedge aclk) begin
        if (cmd.latch_entry) begin
            kind_reg  <= in_kind;
            addr_reg  <= in_addr;
            value_reg <= in_value;
            mask_reg  <= in_mask;
        end
        if (cmd.decide) begin
            post_reg <= post_comb;
        end
    end

    // Burst state: gather, advance, clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= WID_NONE;
            start_reg  <= '0;
            next_reg   <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
            idx_reg    <= '0;
            w32_reg    <= '0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.flush_clear) begin
                pend_reg <= WID_NONE;
                cnt_reg  <= '0;
            end else if (cmd.wr_hi || cmd.wr_lo) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.wr_lo) begin
                next_reg <= addr_reg + 16'(step);
                if (pend_reg == WID_NONE) begin
                    pend_reg  <= code;
                    start_reg <= addr_reg;
                end
            end
            if (cmd.latch_entry) begin
                w32_reg <= '0;
            end else if (cmd.emit_sel == EM_W32) begin
                w32_reg <= w32_reg + 3'd1;
            end
            if (cmd.emit_sel == EM_SINGLE && is_bad) begin
                halted_reg <= 1'b1;
            end
        end
    end

    // Output valid: set on load, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_sel != EM_NONE) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_sel != EM_NONE) begin
            type_reg  <= REC_BYTE;
            byte_reg  <= '0;
            end_reg   <= 1'b0;
            caddr_reg <= '0;
            cval_reg  <= '0;
            cmask_reg <= '0;
            last_reg  <= cmd.run_last;
            case (cmd.emit_sel)
                EM_ADDR_HI: byte_reg <= start_reg[15:8];
                EM_ADDR_LO: begin
                    byte_reg <= start_reg[7:0];
                    end_reg  <= (cnt_reg == '0);
                end
                EM_BUF: begin
                    byte_reg <= rd_data_reg;
                    end_reg  <= ((idx_reg + CNT_W'(1)) == cnt_reg);
                end
                EM_W32: begin
                    byte_reg <= w32_byte;
                    end_reg  <= (w32_reg == W32_LAST_BYTE);
                end
                EM_SINGLE: begin
                    case (kind_reg)
                        KIND_POLL16: begin
                            type_reg  <= REC_POLL;
                            caddr_reg <= addr_reg;
                            cval_reg  <= value_reg[15:0];
                            cmask_reg <= mask_reg;
                        end
                        KIND_WAIT: begin
                            type_reg <= REC_WAIT;
                            cval_reg <= (value_reg[31:16] != '0) ? 16'hFFFF
                                                                 : value_reg[15:0];
                        end
                        KIND_END: type_reg <= REC_DONE;
                        default:  type_reg <= REC_ERROR;
                    endcase
                end
                default: type_reg <= REC_BYTE;
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_type  = type_reg;
    assign out_byte  = byte_reg;
    assign out_end   = end_reg;
    assign out_caddr = caddr_reg;
    assign out_cval  = cval_reg;
    assign out_cmask = cmask_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_BURST_BYTES))
        else $error("burst byte count beyond capacity");

    // The high byte of a fresh 16-bit burst lands in the cycle before the burst opens
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == WID_NONE && !cmd.wr_lo) |-> cnt_reg == '0)
        else $error("bytes held with no burst pending");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sel != EM_NONE |-> (!valid_reg || out_ready))
        else $error("output register overwritten before taken");
`endif

endmodule

@@ design/register_table_burst_packer.sv @@
// Top level of the register-table burst packer.
// Joins rtbp_ctrl and rtbp_dp and packs the stream words; depends on rtbp_pkg.
//
//   channel | dir | tdata (low bit up)                         | tuser        | tlast
//   s_      | in  | reg_addr, entry_value, poll_mask (64 bits)  | entry_kind   | -
//   m_      | out | message_byte, message_end, command_addr,    | record_type  | run_last
//           |     | command_value, command_mask, zero fill      |              |
//
// An entry is latched in ST_IDLE and decided in ST_DECIDE; a buffered write
// then passes through ST_WR_HI (16-bit only) and ST_WR_LO. A burst flush
// sends 2 + N records for N buffered bytes; records go out only while the
// output register is free or being taken. The pace is set by the single
// output register and the one-byte-per-cycle buffer port. Reset clears all
// control state; buffer contents are not cleared. A stalled m_ side holds the
// controller in place without loss; s_tready is high only between entries.
module register_table_burst_packer
    import rtbp_pkg::*;
#(
    parameter int MAX_BURST_BYTES = DEF_MAX_BURST_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // reg_addr[15:0], entry_value[47:16], poll_mask[63:48]
    input  logic [2:0]  s_tuser,   // entry_kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // message_byte[7:0], message_end[8], command_addr[24:9],
                                   // command_value[40:25], command_mask[56:41], zero[63:57]
    output logic [2:0]  m_tuser,   // record_type[2:0]
    output logic        m_tlast    // run_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [7:0]  out_byte;
    logic        out_end;
    logic [15:0] out_caddr;
    logic [15:0] out_cval;
    logic [15:0] out_cmask;

    rtbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtbp_dp #(
        .MAX_BURST_BYTES (MAX_BURST_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (s_tuser),
        .in_addr   (s_tdata[15:0]),
        .in_value  (s_tdata[47:16]),
        .in_mask   (s_tdata[63:48]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_type  (m_tuser),
        .out_byte  (out_byte),
        .out_end   (out_end),
        .out_caddr (out_caddr),
        .out_cval  (out_cval),
        .out_cmask (out_cmask),
        .out_last  (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {7'd0, out_cmask, out_cval, out_caddr, out_end, out_byte};

endmodule

@@ dv/tb_register_table_burst_packer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for register_table_burst_packer.
// Holds a cycle-free predictor of the burst packing, a queue-fed stream driver and
// a checking monitor; depends on rtbp_pkg and the design top level only.
module tb_register_table_burst_packer;
    import rtbp_pkg::*;

    localparam int BURST_CAP = DEF_MAX_BURST_BYTES;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_CAP = 40;

    // Kinds outside the defined set; either one halts the block
    localparam logic [2:0] KIND_BAD_LO = 3'd6;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [31:0] value;
        logic [15:0] mask;
    } table_entry_t;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [7:0]  mbyte;
        logic        msg_end;
        logic [15:0] caddr;
        logic [15:0] cval;
        logic [15:0] cmask;
        logic        run_last;
    } record_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // reg_addr[15:0], entry_value[47:16], poll_mask[63:48]
    logic [2:0]  s_tuser = '0;   // entry_kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // message_byte[7:0], message_end[8], command_addr[24:9],
                                 // command_value[40:25], command_mask[56:41], zero[63:57]
    logic [2:0]  m_tuser;        // record_type[2:0]
    logic        m_tlast;        // run_last

    register_table_burst_packer #(
        .MAX_BURST_BYTES(BURST_CAP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    table_entry_t entry_queue[$];
    record_t      expected_records[$];
    record_t      step_records[$];
    table_entry_t offered;
    record_t      due;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left;

    int mismatches = 0;
    int entries_taken = 0;
    int records_seen = 0;
    int messages_seen = 0;
    int commands_seen = 0;

    // Predictor state: the burst being gathered
    logic [1:0]  burst_width = WID_NONE;
    logic [15:0] burst_start = '0;
    logic [15:0] burst_next = '0;
    int          burst_len = 0;
    logic [7:0]  burst_bytes[BURST_CAP];
    bit          halted = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ---------------------------------------------------------------- predictor
    function automatic void put_record(input logic [2:0] rt, input logic [7:0] b,
                                       input logic e, input logic [15:0] ca,
                                       input logic [15:0] cv, input logic [15:0] cm);
        record_t r;
        r = '{rt, b, e, ca, cv, cm, 1'b0};
        step_records.push_back(r);
    endfunction

    // Send the gathered burst as one message: start address, then data bytes
    function automatic void send_burst();
        int i;
        if (burst_width == WID_NONE)
            return;
        put_record(REC_BYTE, burst_start[15:8], 1'b0, '0, '0, '0);
        put_record(REC_BYTE, burst_start[7:0], burst_len == 0, '0, '0, '0);
        for (i = 0; i < burst_len; i++)
            put_record(REC_BYTE, burst_bytes[i], i + 1 == burst_len, '0, '0, '0);
        burst_width = WID_NONE;
        burst_len = 0;
    endfunction

    // Add a 16-bit or 8-bit write to the burst, sending first or after as needed
    function automatic void gather_write(input logic [1:0] wid, input int stride,
                                         input logic [15:0] addr, input logic [15:0] data);
        int k;
        int nxt;
        if (burst_width != wid || addr != burst_next)
            send_burst();
        if (burst_width == WID_NONE) begin
            burst_width = wid;
            burst_start = addr;
            burst_next = addr;
            burst_len = 0;
        end
        for (k = 0; k < stride; k++) begin
            if (burst_len < BURST_CAP) begin
                burst_bytes[burst_len] = (stride == 2 && k == 0) ? data[15:8] : data[7:0];
                burst_len++;
            end
        end
        nxt = int'(addr) + stride;
        // never let a burst run past the top of the address space
        if (nxt > 32'hFFFF) begin
            send_burst();
            return;
        end
        burst_next = nxt[15:0];
        if (burst_len + stride > BURST_CAP)
            send_burst();
    endfunction

    // Work out every record one accepted entry causes and queue them
    function automatic void pack_entry(input table_entry_t e);
        step_records.delete();
        if (halted)
            return;
        case (e.kind)
            KIND_WRITE32: begin
                send_burst();
                put_record(REC_BYTE, e.addr[15:8], 1'b0, '0, '0, '0);
                put_record(REC_BYTE, e.addr[7:0], 1'b0, '0, '0, '0);
                put_record(REC_BYTE, e.value[31:24], 1'b0, '0, '0, '0);
                put_record(REC_BYTE, e.value[23:16], 1'b0, '0, '0, '0);
                put_record(REC_BYTE, e.value[15:8], 1'b0, '0, '0, '0);
                put_record(REC_BYTE, e.value[7:0], 1'b1, '0, '0, '0);
            end
            KIND_WRITE16: gather_write(WID_16, 2, e.addr, e.value[15:0]);
            KIND_WRITE8:  gather_write(WID_8, 1, e.addr, {8'h00, e.value[7:0]});
            KIND_POLL16: begin
                send_burst();
                put_record(REC_POLL, '0, 1'b0, e.addr, e.value[15:0], e.mask);
            end
            KIND_WAIT: begin
                send_burst();
                // saturate long waits to the 16-bit count
                put_record(REC_WAIT, '0, 1'b0, '0,
                           (e.value > 32'hFFFF) ? 16'hFFFF : e.value[15:0], '0);
            end
            KIND_END: begin
                send_burst();
                put_record(REC_DONE, '0, 1'b0, '0, '0, '0);
            end
            default: begin
                send_burst();
                put_record(REC_ERROR, '0, 1'b0, '0, '0, '0);
                halted = 1'b1;
            end
        endcase
        if (step_records.size() > 0)
            step_records[step_records.size() - 1].run_last = 1'b1;
        foreach (step_records[i])
            expected_records.push_back(step_records[i]);
    endfunction

    // ------------------------------------------------------------------- driver
    // Predict on acceptance, then offer the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                pack_entry(offered);
                entries_taken++;
            end
            if (entry_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                offered = entry_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {offered.mask, offered.value, offered.addr};
                s_tuser <= offered.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------ monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            records_seen++;
            if (expected_records.size() == 0) begin
                report_mismatch("record with none expected, type", 32'(m_tuser), 32'd0);
            end else begin
                due = expected_records.pop_front();
                if (due.rtype == REC_BYTE && due.msg_end)
                    messages_seen++;
                if (due.rtype == REC_POLL || due.rtype == REC_WAIT)
                    commands_seen++;
                compare_field("record_type", 32'(m_tuser), 32'(due.rtype));
                compare_field("message_byte", 32'(m_tdata[7:0]), 32'(due.mbyte));
                compare_field("message_end", 32'(m_tdata[8]), 32'(due.msg_end));
                compare_field("command_addr", 32'(m_tdata[24:9]), 32'(due.caddr));
                compare_field("command_value", 32'(m_tdata[40:25]), 32'(due.cval));
                compare_field("command_mask", 32'(m_tdata[56:41]), 32'(due.cmask));
                compare_field("zero fill", 32'(m_tdata[63:57]), 32'd0);
                compare_field("run_last", 32'(m_tlast), 32'(due.run_last));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_entry(input logic [2:0] kind, input logic [15:0] addr,
                             input logic [31:0] value, input logic [15:0] mask);
        entry_queue.push_back('{kind, addr, value, mask});
    endtask

    // Corners of every field, every kind, and each flush reason but a full burst
    task automatic queue_directed();
        add_entry(KIND_WRITE32, 16'h0000, 32'h0000_0000, 16'h0000);
        add_entry(KIND_WRITE32, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_entry(KIND_WRITE16, 16'h1000, 32'hFFFF_ABCD, 16'h0000);
        add_entry(KIND_WRITE16, 16'h1002, 32'h0000_1234, 16'hFFFF);
        add_entry(KIND_WRITE16, 16'h1006, 32'h5555_AAAA, 16'h0000);   // address gap
        add_entry(KIND_WRITE8,  16'h1008, 32'h0000_00FF, 16'h0000);   // width change
        add_entry(KIND_WRITE8,  16'h1009, 32'h1234_5680, 16'h0000);
        add_entry(KIND_POLL16,  16'h2000, 32'hFFFF_5A5A, 16'hF0F0);   // flush before poll
        add_entry(KIND_POLL16,  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_entry(KIND_WAIT,    16'h0000, 32'h0000_0000, 16'h0000);
        add_entry(KIND_WAIT,    16'h1234, 32'h0000_FFFF, 16'h0000);
        add_entry(KIND_WAIT,    16'h0000, 32'h0001_0000, 16'h0000);   // saturates
        add_entry(KIND_WAIT,    16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
        add_entry(KIND_WRITE16, 16'hFFFE, 32'h0000_BEEF, 16'h0000);   // top of address space
        add_entry(KIND_WRITE8,  16'hFFFF, 32'h0000_007E, 16'h0000);
        add_entry(KIND_WRITE16, 16'hFFFF, 32'h0000_CAFE, 16'h0000);
        add_entry(KIND_WRITE8,  16'h0010, 32'h0000_00A5, 16'h0000);
        add_entry(KIND_END,     16'h0000, 32'h0000_0000, 16'h0000);   // end with burst pending
        add_entry(KIND_END,     16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_entry(KIND_WRITE16, 16'h3000, 32'h0000_1111, 16'h0000);
        add_entry(KIND_WRITE32, 16'h3002, 32'hDEAD_BEEF, 16'h0000);   // flush before write32
        add_entry(KIND_WRITE8,  16'h3100, 32'h0000_0001, 16'h0000);
        add_entry(KIND_WAIT,    16'h0000, 32'h0000_0005, 16'h0000);
        add_entry(KIND_WRITE16, 16'h3200, 32'h0000_2222, 16'h0000);
        add_entry(KIND_WRITE8,  16'h3202, 32'h0000_0033, 16'h0000);
    endtask

    // Mostly contiguous write runs with random content, plus commands and noise
    task automatic queue_random_entries(input int count);
        int added;
        int pick;
        int len;
        int i;
        int stride;
        logic [2:0] kind;
        logic [15:0] addr;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                kind = $urandom_range(1) ? KIND_WRITE16 : KIND_WRITE8;
                stride = (kind == KIND_WRITE16) ? 2 : 1;
                len = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                // keep the phase at its word count
                if (len > count - added)
                    len = count - added;
                addr = ($urandom_range(7) == 0) ? 16'(16'hFFFF - $urandom_range(12))
                                                : 16'($urandom);
                for (i = 0; i < len; i++) begin
                    add_entry(kind, addr, $urandom, 16'($urandom));
                    addr = addr + 16'(stride);
                    // now and then break the run
                    if ($urandom_range(11) == 0)
                        addr = addr + 16'($urandom_range(1, 3));
                end
                added += len;
            end else begin
                if (pick < 70)
                    add_entry(KIND_WRITE32, 16'($urandom), $urandom, 16'($urandom));
                else if (pick < 80)
                    add_entry(KIND_POLL16, 16'($urandom), $urandom, 16'($urandom));
                else if (pick < 90)
                    add_entry(KIND_WAIT, 16'($urandom),
                              $urandom_range(1) ? $urandom : $urandom_range(0, 70000),
                              16'($urandom));
                else if (pick < 94)
                    add_entry(KIND_END, 16'($urandom), $urandom, 16'($urandom));
                else
                    add_entry(3'($urandom_range(5)), 16'($urandom), $urandom,
                              16'($urandom));
                added++;
            end
        end
    endtask

    // Full-size bursts of both widths, so a held-off receiver backs up the input
    task automatic queue_full_bursts();
        int i;
        for (i = 0; i < BURST_CAP / 2; i++)
            add_entry(KIND_WRITE16, 16'(16'h4000 + 2 * i), $urandom, 16'($urandom));
        add_entry(KIND_WRITE32, 16'h4800, $urandom, 16'($urandom));
        for (i = 0; i < BURST_CAP; i++)
            add_entry(KIND_WRITE8, 16'(16'h5000 + i), $urandom, 16'($urandom));
        add_entry(KIND_WRITE8, 16'h6000, $urandom, 16'($urandom));
        add_entry(KIND_POLL16, 16'($urandom), $urandom, 16'($urandom));
    endtask

    // Invalid kind with a burst pending, then entries the halted block must drop
    task automatic queue_halt_tail();
        logic bad_hi;
        bad_hi = 1'($urandom_range(1));
        add_entry(KIND_WRITE8, 16'h7000, $urandom, 16'($urandom));
        add_entry(KIND_WRITE8, 16'h7001, $urandom, 16'($urandom));
        add_entry(bad_hi ? KIND_BAD_HI : KIND_BAD_LO, 16'($urandom), $urandom,
                  16'($urandom));
        add_entry(bad_hi ? KIND_BAD_LO : KIND_BAD_HI, 16'($urandom), $urandom,
                  16'($urandom));
        add_entry(KIND_WRITE32, 16'($urandom), $urandom, 16'($urandom));
        add_entry(KIND_WRITE16, 16'($urandom), $urandom, 16'($urandom));
        add_entry(KIND_END, 16'($urandom), $urandom, 16'($urandom));
    endtask

    // Wait for every queued word to be taken and every record to arrive
    task automatic wait_drain();
        while (entry_queue.size() != 0 || s_tvalid || expected_records.size() != 0)
            @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        wait_drain();

        // idling phases: none, sender, receiver, both
        send_idle_pct = 0;  recv_stall_pct = 0;  queue_random_entries(17);  wait_drain();
        send_idle_pct = 69; recv_stall_pct = 0;  queue_random_entries(17);  wait_drain();
        send_idle_pct = 0;  recv_stall_pct = 69; queue_random_entries(17);  wait_drain();
        send_idle_pct = 37; recv_stall_pct = 37; queue_random_entries(17);  wait_drain();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        queue_full_bursts();
        wait_drain();

        send_idle_pct = 37;
        recv_stall_pct = 37;
        queue_halt_tail();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d table entries giving %0d records: %0d bus messages, %0d commands,",
                 entries_taken, records_seen, messages_seen, commands_seen);
        $display("all idle and stall mixes, a long output hold-off and a halting invalid kind");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/rtbp_pkg.sv
design/rtbp_ctrl.sv
design/rtbp_dp.sv
design/register_table_burst_packer.sv
dv/tb_register_table_burst_packer.sv
